[design/tccs_pkg.sv]
package tccs_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;

  // Field and counter widths
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned POS_W  = 11;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned ADDR_W = 3;

  // Cell contents
  localparam logic [7:0] RESET_ATTR   = 8'h07;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] CHAR_LF      = 8'd10;

  // Request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Register map: register index taken from paddr above the byte offset
  localparam logic REG_TEXT_ATTR = 1'b0;

endpackage

[design/text_console_cursor_scroll.sv]
// Text console engine: a 25 x 80 grid of 16-bit cells (attribute high, character
// low) in one single-port-write, single-port-read memory, plus a cursor. A
// transaction is taken when start is high and busy is low; busy stays high
// until the result has been shown. Each transaction gives exactly one result,
// shown for one cycle with done_o high, which the receiver must take then: it
// cannot stall the block. Put, carriage return, line feed without scroll,
// read and unused codes go from idle straight to the result state. A line
// feed or wrap on the last row scrolls: the memory is copied up one row at
// one cell per cycle and the bottom row blanked. Clear blanks every cell at
// one cell per cycle. After reset the block runs a clearing pass over every
// cell with busy high; configuration writes are taken during it as at any
// time.
module text_console_cursor_scroll (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type_i,
  input  logic [7:0]                   char_code_i,
  input  logic [tccs_pkg::POS_W-1:0]   cell_index_i,
  output logic                         done_o,
  output logic [tccs_pkg::POS_W-1:0]   cursor_pos_o,
  output logic [tccs_pkg::CELL_W-1:0]  read_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tccs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned POS_W  = tccs_pkg::POS_W;
  localparam int unsigned COL_W  = tccs_pkg::COL_W;
  localparam int unsigned ROW_W  = tccs_pkg::ROW_W;
  localparam int unsigned CELL_W = tccs_pkg::CELL_W;
  localparam int unsigned ADDR_W_HI = 2;

  localparam logic [POS_W-1:0] LAST_CELL    = POS_W'(tccs_pkg::CELL_COUNT - 1);
  localparam logic [POS_W-1:0] CELL_END     = POS_W'(tccs_pkg::CELL_COUNT);
  localparam logic [POS_W-1:0] ROW_STEP     = POS_W'(tccs_pkg::COLUMNS);
  localparam logic [POS_W-1:0] BOTTOM_ROW   = POS_W'((tccs_pkg::ROWS - 1) * tccs_pkg::COLUMNS);
  localparam logic [POS_W-1:0] LAST_COPY    = POS_W'(tccs_pkg::CELL_COUNT
                                                     - tccs_pkg::COLUMNS - 1);
  localparam logic [COL_W-1:0] LAST_COL     = COL_W'(tccs_pkg::COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW     = ROW_W'(tccs_pkg::ROWS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FILL   = 3'd1;
  localparam logic [2:0] ST_PRIME  = 3'd2;
  localparam logic [2:0] ST_COPY   = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  ptr_q, ptr_d;
  logic [7:0]        attr_q, attr_d;
  logic [CELL_W-1:0] fill_q, fill_d;
  logic              emit_q, emit_d;
  logic              rd_req_q, rd_req_d;

  logic              mem_we, mem_re;
  logic [POS_W-1:0]  mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] rdata_q;
  logic [CELL_W-1:0] screen_mem [tccs_pkg::CELL_COUNT];

  logic accept;
  logic cfg_write;
  logic adv_row;

  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration port: one register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W_HI] == tccs_pkg::REG_TEXT_ATTR) ? {24'd0, attr_q} : 32'd0;

  // Sequencer: request decode, scroll copy, fill sweeps and result cycle
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    pos_d     = pos_q;
    ptr_d     = ptr_q;
    attr_d    = attr_q;
    fill_d    = fill_q;
    emit_d    = emit_q;
    rd_req_d  = rd_req_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ptr_q;
    mem_raddr = ptr_q + ROW_STEP + POS_W'(1);
    mem_wdata = fill_q;
    adv_row   = 1'b0;

    if (cfg_write && (paddr[ADDR_W_HI] == tccs_pkg::REG_TEXT_ATTR)) begin
      attr_d = pwdata[7:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d  = ST_RESP;
          rd_req_d = 1'b0;
          case (req_type_i)
            tccs_pkg::REQ_PUT: begin
              if (char_code_i == tccs_pkg::CHAR_CR) begin
                col_d = '0;
                pos_d = pos_q - POS_W'(col_q);
              end else if (char_code_i == tccs_pkg::CHAR_LF) begin
                adv_row = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_q;
                mem_wdata = {attr_q, char_code_i};
                if (col_q == LAST_COL) begin
                  adv_row = 1'b1;
                end else begin
                  col_d = col_q + COL_W'(1);
                  pos_d = pos_q + POS_W'(1);
                end
              end
              // Move to the next row, scrolling from the last one
              if (adv_row) begin
                col_d = '0;
                if (row_q == LAST_ROW) begin
                  pos_d   = BOTTOM_ROW;
                  fill_d  = {attr_q, tccs_pkg::BLANK_CHAR};
                  emit_d  = 1'b1;
                  state_d = ST_PRIME;
                end else begin
                  row_d = row_q + ROW_W'(1);
                  pos_d = pos_q - POS_W'(col_q) + ROW_STEP;
                end
              end
            end
            tccs_pkg::REQ_CLEAR: begin
              attr_d  = tccs_pkg::RESET_ATTR;
              fill_d  = {tccs_pkg::RESET_ATTR, tccs_pkg::BLANK_CHAR};
              col_d   = '0;
              row_d   = '0;
              pos_d   = '0;
              ptr_d   = '0;
              emit_d  = 1'b1;
              state_d = ST_FILL;
            end
            tccs_pkg::REQ_READ: begin
              if (cell_index_i < CELL_END) begin
                mem_re    = 1'b1;
                mem_raddr = cell_index_i;
                rd_req_d  = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PRIME: begin
        // Fetch the first cell of row one
        mem_re    = 1'b1;
        mem_raddr = ROW_STEP;
        ptr_d     = '0;
        state_d   = ST_COPY;
      end
      ST_COPY: begin
        // Write back the cell fetched last cycle one row higher, fetch the next
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        if (ptr_q == LAST_COPY) begin
          ptr_d   = BOTTOM_ROW;
          state_d = ST_FILL;
        end else begin
          mem_re = 1'b1;
          ptr_d  = ptr_q + POS_W'(1);
        end
      end
      ST_FILL: begin
        // Blank one cell per cycle up to the end of the grid
        mem_we = 1'b1;
        if (ptr_q == LAST_CELL) begin
          state_d = emit_q ? ST_RESP : ST_IDLE;
        end else begin
          ptr_d = ptr_q + POS_W'(1);
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
        emit_d  = 1'b0;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and cursor registers; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FILL;
      col_q    <= '0;
      row_q    <= '0;
      pos_q    <= '0;
      ptr_q    <= '0;
      attr_q   <= tccs_pkg::RESET_ATTR;
      fill_q   <= {tccs_pkg::RESET_ATTR, tccs_pkg::BLANK_CHAR};
      emit_q   <= 1'b0;
      rd_req_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      pos_q    <= pos_d;
      ptr_q    <= ptr_d;
      attr_q   <= attr_d;
      fill_q   <= fill_d;
      emit_q   <= emit_d;
      rd_req_q <= rd_req_d;
    end
  end

  // Screen memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= screen_mem[mem_raddr];
    end
  end

  // Result
  assign done_o       = (state_q == ST_RESP);
  assign cursor_pos_o = pos_q;
  assign read_data_o  = rd_req_q ? rdata_q : '0;

  // Linear cursor position tracks row and column
  a_pos_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) == 32'(row_q) * tccs_pkg::COLUMNS + 32'(col_q))
    else $error("cursor position out of step with row and column");

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block not busy after accepting a transaction");

  // The result strobe lasts one cycle and frees the block
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe not a single cycle");

  // Memory is never written outside the grid
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr < CELL_END))
    else $error("memory write beyond the grid");

endmodule

[tb/text_console_cursor_scroll_tb.sv]
module text_console_cursor_scroll_tb;

  localparam int unsigned COLUMNS    = tccs_pkg::COLUMNS;
  localparam int unsigned ROWS       = tccs_pkg::ROWS;
  localparam int unsigned CELL_COUNT = tccs_pkg::CELL_COUNT;
  localparam int unsigned POS_W      = tccs_pkg::POS_W;
  localparam int unsigned CELL_W     = tccs_pkg::CELL_W;
  localparam int unsigned ADDR_W     = tccs_pkg::ADDR_W;

  localparam logic [1:0]        REQ_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ATTR_ADDR  = {tccs_pkg::REG_TEXT_ATTR, 2'b00};

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] data;
  } console_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        req_type_i;
  logic [7:0]        char_code_i;
  logic [POS_W-1:0]  cell_index_i;
  logic              done_o;
  logic [POS_W-1:0]  cursor_pos_o;
  logic [CELL_W-1:0] read_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Console image kept by the testbench
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  logic [6:0]        cur_col;
  logic [4:0]        cur_row;
  logic [7:0]        attr_model;

  console_result_t pending_results [$];
  int              fail_count;
  int              burst_left;

  text_console_cursor_scroll dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .cell_index_i(cell_index_i),
    .done_o      (done_o),
    .cursor_pos_o(cursor_pos_o),
    .read_data_o (read_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

  // Move the cursor down one row, scrolling the grid on the last row
  function automatic void step_row();
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
        screen_model[i] = {attr_model, tccs_pkg::BLANK_CHAR};
      cur_row = 5'(ROWS - 1);
    end
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {attr_model, tccs_pkg::BLANK_CHAR};
    cur_col = '0;
    cur_row = '0;
  endfunction

  // Apply one request to the console image and return the result it gives
  function automatic console_result_t console_apply(input logic [1:0] req,
                                                    input logic [7:0] ch,
                                                    input logic [POS_W-1:0] idx);
    console_result_t r;
    r.data = '0;
    case (req)
      tccs_pkg::REQ_PUT: begin
        if (ch == tccs_pkg::CHAR_CR) begin
          cur_col = '0;
        end else if (ch == tccs_pkg::CHAR_LF) begin
          cur_col = '0;
          step_row();
        end else begin
          screen_model[cur_row * COLUMNS + cur_col] = {attr_model, ch};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = '0;
          step_row();
        end
      end
      tccs_pkg::REQ_CLEAR: begin
        attr_model = tccs_pkg::RESET_ATTR;
        blank_screen();
      end
      tccs_pkg::REQ_READ: begin
        if (idx < CELL_COUNT) r.data = screen_model[idx];
      end
      default: ;
    endcase
    r.pos = POS_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  // Mostly cells on the cursor row, some anywhere, a few past the grid
  function automatic logic [POS_W-1:0] pick_cell_index();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return POS_W'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
    if (sel < 9) return POS_W'($urandom_range(0, CELL_COUNT - 1));
    return POS_W'($urandom_range(CELL_COUNT, 2047));
  endfunction

  // Insert idle gaps between bursts of transactions
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      @(negedge clk_i) start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
  endtask

  // Present one transaction, hold it until taken, then predict its result
  task automatic send_request(input logic [1:0] req, input logic [7:0] ch,
                              input logic [POS_W-1:0] idx);
    pace_sender();
    @(negedge clk_i);
    start        <= 1'b1;
    req_type_i   <= req;
    char_code_i  <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(console_apply(req, ch, idx));
  endtask

  // Hold off until every result is in and the block is idle
  task automatic wait_drained();
    @(negedge clk_i) start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_attr(input logic [7:0] val);
    wait_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {24'h0, val};
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    attr_model = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    console_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: cursor_pos %0d read_data 0x%04h", cursor_pos_o, read_data_o);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (cursor_pos_o !== exp_r.pos) begin
          $error("cursor_pos: expected %0d, got %0d", exp_r.pos, cursor_pos_o);
          fail_count++;
        end
        if (read_data_o !== exp_r.data) begin
          $error("read_data: expected 0x%04h, got 0x%04h", exp_r.data, read_data_o);
          fail_count++;
        end
      end
    end
  end

  task automatic test_power_up();
    send_request(tccs_pkg::REQ_READ, 8'h00, 11'd0);
    send_request(tccs_pkg::REQ_READ, 8'hFF, 11'd1999);
  endtask

  task automatic test_put_extremes();
    send_request(tccs_pkg::REQ_PUT, 8'h00, 11'd0);
    send_request(tccs_pkg::REQ_PUT, 8'hFF, 11'h7FF);
    send_request(tccs_pkg::REQ_PUT, 8'h41, 11'd5);
    for (int i = 0; i < 3; i++) send_request(tccs_pkg::REQ_READ, 8'h00, POS_W'(i));
  endtask

  task automatic test_cr_lf();
    send_request(tccs_pkg::REQ_PUT, tccs_pkg::CHAR_CR, 11'd0);
    send_request(tccs_pkg::REQ_PUT, tccs_pkg::CHAR_LF, 11'd0);
    send_request(tccs_pkg::REQ_READ, 8'h00, 11'd80);
  endtask

  task automatic test_read_out_of_range();
    send_request(tccs_pkg::REQ_READ, 8'h00, POS_W'(CELL_COUNT));
    send_request(tccs_pkg::REQ_READ, 8'h00, 11'h7FF);
  endtask

  task automatic test_unused_request();
    send_request(REQ_UNUSED, 8'hFF, 11'h7FF);
    send_request(REQ_UNUSED, 8'h00, 11'd0);
  endtask

  task automatic test_attr_write();
    write_attr(8'hFF);
    send_request(tccs_pkg::REQ_PUT, 8'h58, 11'd0);
    send_request(tccs_pkg::REQ_READ, 8'h00, 11'd80);
  endtask

  task automatic test_clear();
    send_request(tccs_pkg::REQ_CLEAR, 8'hFF, 11'h7FF);
    send_request(tccs_pkg::REQ_READ, 8'h00, 11'd80);
    send_request(tccs_pkg::REQ_PUT, 8'h5A, 11'd0);
    send_request(tccs_pkg::REQ_READ, 8'h00, 11'd0);
  endtask

  // Text lines, runs of line feeds, clears, reads and noise; the attribute is written once at the start
  task automatic test_random_text(input logic [7:0] attr, input int n_items);
    int sent;
    int kind;
    int len;
    write_attr(attr);
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: len = $urandom_range(0, 8);
          5, 6, 7:       len = $urandom_range(9, 79);
          default:       len = $urandom_range(80, 170);
        endcase
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_request(tccs_pkg::REQ_READ, 8'($urandom), pick_cell_index());
            sent++;
          end
          send_request(tccs_pkg::REQ_PUT, 8'($urandom_range(0, 255)), POS_W'($urandom));
          sent++;
        end
        if ($urandom_range(0, 1) == 1) begin
          send_request(tccs_pkg::REQ_PUT, tccs_pkg::CHAR_CR, POS_W'($urandom));
          sent++;
        end
        send_request(tccs_pkg::REQ_PUT, tccs_pkg::CHAR_LF, POS_W'($urandom));
        sent++;
      end else if (kind < 70) begin
        len = $urandom_range(1, 20);
        for (int k = 0; k < len; k++)
          send_request(tccs_pkg::REQ_PUT, tccs_pkg::CHAR_LF, POS_W'($urandom));
        sent += len;
      end else if (kind < 90) begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
          send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       POS_W'($urandom_range(0, 2047)));
        sent += len;
      end else if (kind < 95) begin
        send_request(tccs_pkg::REQ_CLEAR, 8'($urandom), POS_W'($urandom));
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++)
          send_request(tccs_pkg::REQ_READ, 8'($urandom), pick_cell_index());
        sent += len;
      end
    end
  endtask

  initial begin
    start        = 1'b0;
    req_type_i   = tccs_pkg::REQ_PUT;
    char_code_i  = 8'h00;
    cell_index_i = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    fail_count   = 0;
    burst_left   = 0;
    attr_model   = tccs_pkg::RESET_ATTR;
    blank_screen();

    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    // Let the power-up clearing pass finish
    wait_drained();

    test_power_up();
    test_put_extremes();
    test_cr_lf();
    test_read_out_of_range();
    test_unused_request();
    test_attr_write();
    test_clear();

    test_random_text(8'h00, 290);
    test_random_text(8'hFF, 290);
    test_random_text(8'($urandom_range(0, 255)), 290);
    test_random_text(8'($urandom_range(0, 255)), 290);
    test_random_text(8'($urandom_range(0, 255)), 290);
    test_random_text(tccs_pkg::RESET_ATTR, 290);

    wait_drained();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
